/* design/distance_vector_route_table_top_macros.svh */
// assertion macros for the checker file
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_TOP_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DVRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DVRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dvrt_pkg.sv */
`timescale 1ns / 1ps

package dvrt_pkg;

    localparam int ID_W   = 4;
    localparam int CNT_W  = 5;
    localparam int AGE_W  = 3;
    localparam int COST_W = 15;

    localparam logic [COST_W-1:0] INF_RESET = 15'd32600;
    localparam logic [AGE_W-1:0]  AGE_MAX   = 3'd7;

    localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 5'd8;
    localparam logic [AGE_W-1:0]  AGE_LIMIT_RESET  = 3'd3;

    // input word kinds
    localparam logic [1:0] MODE_VECTOR = 2'd0;
    localparam logic [1:0] MODE_LINK   = 2'd1;
    localparam logic [1:0] MODE_NOTICE = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SELF_ID    = 2'd0;
    localparam logic [1:0] REG_NODE_COUNT = 2'd1;
    localparam logic [1:0] REG_AGE_LIMIT  = 2'd2;
    localparam logic [1:0] REG_INFINITY   = 2'd3;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic issue;    // issue one vector table read of the scan
        logic emit;     // load the next route row into the output register
    } cmd_t;

    typedef struct packed {
        logic trigger;    // the word on the input starts a recompute
        logic scan_last;  // read of the last neighbour/destination pair
        logic emit_last;  // row being loaded is the final one
        logic out_free;   // output register can take a row
    } stat_t;

endpackage

/* design/dvrt_ram.sv */
`timescale 1ns / 1ps

module dvrt_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/dvrt_ctrl.sv */
`timescale 1ns / 1ps

module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.trigger)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last compare lands this cycle
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/dvrt_dp.sv */
`timescale 1ns / 1ps

module dvrt_dp
    import dvrt_pkg::*;
#(
    parameter int NODES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [COST_W-1:0] cfg_wdata,
    input  logic [1:0]        in_mode,
    input  logic [ID_W-1:0]   in_nb,
    input  logic [ID_W-1:0]   in_dest,
    input  logic [COST_W-1:0] in_cost,
    input  logic              in_last,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [ID_W-1:0]   out_dest,
    output logic [COST_W-1:0] out_cost,
    output logic [ID_W-1:0]   out_hop,
    output logic              out_ok,
    output logic              out_last
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int DEPTH  = NODES * NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] NODES_A = ADDR_W'(NODES);
    localparam logic [CNT_W-1:0]  NODES_C = CNT_W'(NODES);

    // configuration
    logic [ID_W-1:0]   self_id_reg,    self_id_next;
    logic [CNT_W-1:0]  node_count_reg, node_count_next;
    logic [AGE_W-1:0]  age_limit_reg,  age_limit_next;
    logic [COST_W-1:0] inf_reg,        inf_next;

    // per-node state
    logic [COST_W-1:0] link_reg [NODES];
    logic [COST_W-1:0] link_next [NODES];
    logic [AGE_W-1:0]  age_reg [NODES];
    logic [AGE_W-1:0]  age_next [NODES];
    logic [NODES-1:0]  flag_reg, flag_next;

    // route scratch built by a recompute
    logic [COST_W-1:0] rc_reg [NODES];
    logic [COST_W-1:0] rc_next [NODES];
    logic [IDX_W-1:0]  hop_reg [NODES];
    logic [IDX_W-1:0]  hop_next [NODES];
    logic [NODES-1:0]  hv_reg, hv_next;

    // vector table valid bits, an entry not yet written reads as INF_RESET (zero on the diagonal)
    logic [DEPTH-1:0]  vt_valid_reg, vt_valid_next;

    // scan counters and read stage
    logic [IDX_W-1:0]  nb_cnt_reg, nb_cnt_next;
    logic [IDX_W-1:0]  d_cnt_reg,  d_cnt_next;
    logic              st_vld_reg;
    logic [IDX_W-1:0]  st_nb_reg, st_d_reg;
    logic              st_hit_reg, st_diag_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_dest_reg, out_dest_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic [ID_W-1:0]   out_hop_reg,  out_hop_next;
    logic              out_ok_reg,   out_ok_next;
    logic              out_last_reg, out_last_next;

    logic [CNT_W-1:0]  n_used;
    logic [IDX_W-1:0]  nb_ix, dest_ix;
    logic              usable, peer_ok, dest_ok;
    logic [COST_W-1:0] cost_sat;

    logic              vt_we;
    logic [ADDR_W-1:0] vt_waddr, vt_raddr;
    logic [COST_W-1:0] vt_rdata, vt_val;
    logic [COST_W:0]   sum;
    logic              win;
    logic              d_last, nb_last;
    logic              row_self, row_route;
    logic [AGE_W-1:0]  age_inc;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_used = CNT_W'(1);
        end
        else if (node_count_reg > NODES_C)
        begin
            n_used = NODES_C;
        end
        else
        begin
            n_used = node_count_reg;
        end
    end

    assign nb_ix    = in_nb[IDX_W-1:0];
    assign dest_ix  = in_dest[IDX_W-1:0];
    assign usable   = (CNT_W'(in_nb) < n_used) && (in_nb != self_id_reg);
    assign peer_ok  = usable && flag_reg[nb_ix];
    assign dest_ok  = CNT_W'(in_dest) < n_used;
    assign cost_sat = (in_cost > inf_reg) ? inf_reg : in_cost;

    assign vt_we    = cmd.accept && (in_mode == MODE_VECTOR) && peer_ok && dest_ok;
    assign vt_waddr = ADDR_W'(nb_ix) * NODES_A + ADDR_W'(dest_ix);
    assign vt_raddr = ADDR_W'(nb_cnt_reg) * NODES_A + ADDR_W'(d_cnt_reg);

    dvrt_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_vt (
        .clk   (clk),
        .we    (vt_we),
        .waddr (vt_waddr),
        .wdata (cost_sat),
        .re    (cmd.issue),
        .raddr (vt_raddr),
        .rdata (vt_rdata)
    );

    assign d_last  = CNT_W'(d_cnt_reg) == (n_used - CNT_W'(1));
    assign nb_last = CNT_W'(nb_cnt_reg) == (n_used - CNT_W'(1));

    // compare stage: link cost plus advertised cost against the best so far
    always_comb
    begin
        if (st_hit_reg)
        begin
            vt_val = vt_rdata;
        end
        else if (st_diag_reg)
        begin
            vt_val = '0;
        end
        else
        begin
            vt_val = INF_RESET;
        end
        sum = {1'b0, link_reg[st_nb_reg]} + {1'b0, vt_val};
        win = st_vld_reg && flag_reg[st_nb_reg]
              && (ID_W'(st_nb_reg) != self_id_reg)
              && (ID_W'(st_d_reg) != self_id_reg)
              && (sum < {1'b0, inf_reg})
              && (sum < {1'b0, rc_reg[st_d_reg]});
    end

    assign row_self  = ID_W'(d_cnt_reg) == self_id_reg;
    assign row_route = hv_reg[d_cnt_reg] && (rc_reg[d_cnt_reg] < inf_reg);

    always_comb
    begin
        self_id_next    = self_id_reg;
        node_count_next = node_count_reg;
        age_limit_next  = age_limit_reg;
        inf_next        = inf_reg;
        flag_next       = flag_reg;
        hv_next         = hv_reg;
        vt_valid_next   = vt_valid_reg;
        nb_cnt_next     = nb_cnt_reg;
        d_cnt_next      = d_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_dest_next   = out_dest_reg;
        out_cost_next   = out_cost_reg;
        out_hop_next    = out_hop_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;
        age_inc         = '0;
        for (int i = 0; i < NODES; i++)
        begin
            link_next[i] = link_reg[i];
            age_next[i]  = age_reg[i];
            rc_next[i]   = rc_reg[i];
            hop_next[i]  = hop_reg[i];
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SELF_ID:    self_id_next    = cfg_wdata[ID_W-1:0];
                REG_NODE_COUNT: node_count_next = cfg_wdata[CNT_W-1:0];
                REG_AGE_LIMIT:  age_limit_next  = cfg_wdata[AGE_W-1:0];
                REG_INFINITY:   inf_next        = cfg_wdata;
                default:        ;
            endcase
        end

        if (cmd.accept)
        begin
            unique case (in_mode)
                MODE_VECTOR:
                begin
                    if (peer_ok)
                    begin
                        age_next[nb_ix] = '0;
                        if (dest_ok)
                        begin
                            vt_valid_next[vt_waddr] = 1'b1;
                        end
                        if (in_last)
                        begin
                            nb_cnt_next = '0;
                            d_cnt_next  = '0;
                            hv_next     = '0;
                            for (int i = 0; i < NODES; i++)
                            begin
                                rc_next[i] = inf_reg;
                            end
                        end
                    end
                end
                MODE_LINK:
                begin
                    if (usable)
                    begin
                        link_next[nb_ix] = cost_sat;
                        if (in_cost < inf_reg)
                        begin
                            flag_next[nb_ix] = 1'b1;
                            age_next[nb_ix]  = '0;
                        end
                        else
                        begin
                            flag_next[nb_ix] = 1'b0;
                        end
                    end
                end
                MODE_NOTICE:
                begin
                    if (peer_ok)
                    begin
                        age_next[nb_ix]  = '0;
                        link_next[nb_ix] = cost_sat;
                    end
                end
                MODE_TICK:
                begin
                    for (int i = 0; i < NODES; i++)
                    begin
                        if ((CNT_W'(i) < n_used) && (ID_W'(i) != self_id_reg))
                        begin
                            age_inc = (age_reg[i] == AGE_MAX) ? AGE_MAX
                                                              : age_reg[i] + AGE_W'(1);
                            age_next[i] = age_inc;
                            if (age_inc > age_limit_reg)
                            begin
                                flag_next[i] = 1'b0;
                                link_next[i] = inf_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.issue)
        begin
            if (d_last)
            begin
                d_cnt_next  = '0;
                nb_cnt_next = nb_last ? '0 : nb_cnt_reg + IDX_W'(1);
            end
            else
            begin
                d_cnt_next = d_cnt_reg + IDX_W'(1);
            end
        end

        if (win)
        begin
            rc_next[st_d_reg]  = sum[COST_W-1:0];
            hop_next[st_d_reg] = st_nb_reg;
            hv_next[st_d_reg]  = 1'b1;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_dest_next  = ID_W'(d_cnt_reg);
            out_last_next  = d_last;
            d_cnt_next     = d_last ? '0 : d_cnt_reg + IDX_W'(1);
            if (row_self)
            begin
                out_cost_next = '0;
                out_hop_next  = self_id_reg;
                out_ok_next   = 1'b1;
            end
            else if (row_route)
            begin
                out_cost_next = rc_reg[d_cnt_reg];
                out_hop_next  = ID_W'(hop_reg[d_cnt_reg]);
                out_ok_next   = 1'b1;
            end
            else
            begin
                out_cost_next = inf_reg;
                out_hop_next  = '0;
                out_ok_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg    <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            age_limit_reg  <= AGE_LIMIT_RESET;
            inf_reg        <= INF_RESET;
            flag_reg       <= '0;
            hv_reg         <= '0;
            vt_valid_reg   <= '0;
            nb_cnt_reg     <= '0;
            d_cnt_reg      <= '0;
            st_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NODES; i++)
            begin
                link_reg[i] <= INF_RESET;
                age_reg[i]  <= '0;
            end
        end
        else
        begin
            self_id_reg    <= self_id_next;
            node_count_reg <= node_count_next;
            age_limit_reg  <= age_limit_next;
            inf_reg        <= inf_next;
            flag_reg       <= flag_next;
            hv_reg         <= hv_next;
            vt_valid_reg   <= vt_valid_next;
            nb_cnt_reg     <= nb_cnt_next;
            d_cnt_reg      <= d_cnt_next;
            st_vld_reg     <= cmd.issue;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < NODES; i++)
            begin
                link_reg[i] <= link_next[i];
                age_reg[i]  <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_nb_reg    <= nb_cnt_reg;
        st_d_reg     <= d_cnt_reg;
        st_hit_reg   <= vt_valid_reg[vt_raddr];
        st_diag_reg  <= nb_cnt_reg == d_cnt_reg;
        out_dest_reg <= out_dest_next;
        out_cost_reg <= out_cost_next;
        out_hop_reg  <= out_hop_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < NODES; i++)
        begin
            rc_reg[i]  <= rc_next[i];
            hop_reg[i] <= hop_next[i];
        end
    end

    assign stat.trigger   = (in_mode == MODE_VECTOR) && peer_ok && in_last;
    assign stat.scan_last = d_last && nb_last;
    assign stat.emit_last = d_last;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_dest  = out_dest_reg;
    assign out_cost  = out_cost_reg;
    assign out_hop   = out_hop_reg;
    assign out_ok    = out_ok_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/distance_vector_route_table_top.sv */
// a word that does not end a vector is taken while idle with no scan; a final vector entry starts
// a table scan (one vector table read per neighbour/destination pair on the single
// ram read port) and then n rows at one per cycle while the output is not stalled, n = used nodes
// a new word is taken once the last row sits in the output register
// reset (rst_n, async, active low) restores config, link costs, flags and ages at once;
// the vector table uses per-entry valid bits, so there is no clearing pass
`timescale 1ns / 1ps

module distance_vector_route_table_top
    import dvrt_pkg::*;
#(
    parameter int NODES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // neighbour_id[3:0], dest_id[7:4], cost[22:8]
    input  logic [1:0]  s_tuser,    // mode[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // route_dest[3:0], route_cost[18:4], hop_id[22:19]
    output logic [0:0]  m_tuser,    // reachable[0]
    output logic        m_tlast
);

    cmd_t              cmd;
    stat_t             stat;
    logic [ID_W-1:0]   row_dest;
    logic [COST_W-1:0] row_cost;
    logic [ID_W-1:0]   row_hop;
    logic              row_ok;

    dvrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    dvrt_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_mode   (s_tuser),
        .in_nb     (s_tdata[3:0]),
        .in_dest   (s_tdata[7:4]),
        .in_cost   (s_tdata[22:8]),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_dest  (row_dest),
        .out_cost  (row_cost),
        .out_hop   (row_hop),
        .out_ok    (row_ok),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, row_hop, row_cost, row_dest};
    assign m_tuser = row_ok;

endmodule

/* design/dvrt_checker.sv */
`timescale 1ns / 1ps
`include "distance_vector_route_table_top_macros.svh"

module dvrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled row holds
    `DVRT_ASSERT_NEXT(a_row_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "row changed while stalled")

    // no input taken while a table is only partly emitted
    `DVRT_ASSERT_NOW(a_no_accept_mid_table, m_tvalid && !m_tlast, !s_tready, "input ready during table emit")

    // rows only appear after a scan, never right after an accepted word
    `DVRT_ASSERT_NEXT(a_no_instant_row, s_tvalid && s_tready, !$rose(m_tvalid), "row right after accepted word")

    // an unreachable row carries next hop zero
    `DVRT_ASSERT_NOW(a_unreach_hop, m_tvalid && !m_tuser[0], m_tdata[22:19] == 4'd0, "unreachable row with next hop")

endmodule

bind distance_vector_route_table_top dvrt_checker u_dvrt_checker (.*);
